@@ rtl/core/prime_removal_filter_defines.svh @@
// Assertion macros shared by the RTL.
`ifndef PRIME_REMOVAL_FILTER_DEFINES_SVH
`define PRIME_REMOVAL_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/prf_pkg.sv @@
package prf_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);
  localparam int PC_WIDTH    = 4;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   end_mark;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value_out;
    logic                   keep;
    logic                   end_mark_out;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_NEXT_D,
    OP_SET_KEEP,
    OP_CLR_KEEP,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic take;
  } ctrl_t;

  typedef struct packed {
    logic item_valid;
    logic n_lt_2;
    logic sq_gt_n;
    logic div_busy;
    logic rem_zero;
    logic out_busy;
  } flags_t;

endpackage

@@ rtl/core/prime_removal_filter.sv @@
// Channel | Signals                           | Direction | Moves
// item    | item_valid, item_ready, item      | in        | value, end_mark
// result  | result_valid, result_ready, result | out       | value_out, keep, end_mark_out
//
// One item at a time; a prime runs through every trial divisor d with d*d <= n
// (up to 254 of them for a 16-bit value).
// A composite stops at the first trial divisor that divides it.
// The remainder unit works one bit per cycle.
// Reset clears the sequencer's program counter and the result valid flag.
// A stalled result waits in the output register; the next item is taken meanwhile.
module prime_removal_filter
  import prf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  `include "prime_removal_filter_defines.svh"

  ctrl_t  ctrl;
  flags_t flags;

  logic [VALUE_WIDTH-1:0] n;
  logic                   end_mark;
  logic [VALUE_WIDTH-1:0] d;
  logic [VALUE_WIDTH:0]   sq;
  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH-1:0] quot;
  logic [CNT_WIDTH-1:0]   cnt;
  logic                   keep;

  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;
  logic [VALUE_WIDTH-1:0] rem_next;
  logic                   out_free;
  logic                   emit;

  prf_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign trial    = {rem, quot[VALUE_WIDTH-1]};
  assign diff     = trial - {1'b0, d};
  assign rem_next = (trial >= {1'b0, d}) ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];

  assign out_free = !result_valid || result_ready;
  assign emit     = (ctrl.op == OP_EMIT) && out_free;

  assign flags.item_valid = item_valid;
  assign flags.n_lt_2     = (n < VALUE_WIDTH'(2));
  assign flags.sq_gt_n    = (sq > {1'b0, n});
  assign flags.div_busy   = (cnt != CNT_WIDTH'(1));
  assign flags.rem_zero   = (rem == '0);
  assign flags.out_busy   = !out_free;

  assign item_ready = ctrl.take;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        n        <= item.value;
        end_mark <= item.end_mark;
        d        <= VALUE_WIDTH'(2);
        sq       <= (VALUE_WIDTH + 1)'(4);
      end
      OP_DIV_INIT: begin
        rem  <= '0;
        quot <= n;
        cnt  <= CNT_WIDTH'(VALUE_WIDTH);
      end
      OP_DIV_STEP: begin
        rem  <= rem_next;
        quot <= {quot[VALUE_WIDTH-2:0], 1'b0};
        cnt  <= cnt - CNT_WIDTH'(1);
      end
      OP_NEXT_D: begin
        d  <= d + VALUE_WIDTH'(1);
        sq <= sq + {d, 1'b1};
      end
      OP_SET_KEEP: begin
        keep <= 1'b1;
      end
      OP_CLR_KEEP: begin
        keep <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.value_out    <= n;
      result.keep         <= keep;
      result.end_mark_out <= end_mark;
    end
  end

  `PRF_ASSERT_NEXT(a_one_item_at_a_time, item_valid && item_ready, !item_ready, "item taken while busy")
  `PRF_ASSERT_SAME(a_removed_at_least_two, result_valid && !result.keep, result.value_out >= VALUE_WIDTH'(2), "value below two removed")
  `PRF_ASSERT_SAME(a_even_kept, result_valid && !result.value_out[0] && (result.value_out > VALUE_WIDTH'(2)), result.keep, "even value above two removed")

endmodule

@@ rtl/core/prf_seq.sv @@
module prf_seq
  import prf_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  flags_t flags,
  output ctrl_t  ctrl
);

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_N_LT_2,
    C_SQ_GT_N,
    C_DIV_BUSY,
    C_REM_ZERO,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t                 op;
    cond_t               cond;
    logic [PC_WIDTH-1:0] target;
  } uword_t;

  localparam logic [PC_WIDTH-1:0] StIdle    = PC_WIDTH'(0);
  localparam logic [PC_WIDTH-1:0] StLimit   = PC_WIDTH'(2);
  localparam logic [PC_WIDTH-1:0] StDivStep = PC_WIDTH'(4);
  localparam logic [PC_WIDTH-1:0] StKeep    = PC_WIDTH'(7);
  localparam logic [PC_WIDTH-1:0] StDrop    = PC_WIDTH'(8);
  localparam logic [PC_WIDTH-1:0] StEmit    = PC_WIDTH'(9);

  function automatic uword_t program_word(input logic [PC_WIDTH-1:0] addr);
    uword_t w;
    case (addr)
      PC_WIDTH'(0):  w = '{OP_LOAD,     C_NO_ITEM,  StIdle};
      PC_WIDTH'(1):  w = '{OP_NONE,     C_N_LT_2,   StKeep};
      PC_WIDTH'(2):  w = '{OP_NONE,     C_SQ_GT_N,  StDrop};
      PC_WIDTH'(3):  w = '{OP_DIV_INIT, C_NEVER,    StIdle};
      PC_WIDTH'(4):  w = '{OP_DIV_STEP, C_DIV_BUSY, StDivStep};
      PC_WIDTH'(5):  w = '{OP_NONE,     C_REM_ZERO, StKeep};
      PC_WIDTH'(6):  w = '{OP_NEXT_D,   C_ALWAYS,   StLimit};
      PC_WIDTH'(7):  w = '{OP_SET_KEEP, C_ALWAYS,   StEmit};
      PC_WIDTH'(8):  w = '{OP_CLR_KEEP, C_NEVER,    StIdle};
      PC_WIDTH'(9):  w = '{OP_EMIT,     C_OUT_BUSY, StEmit};
      default:       w = '{OP_NONE,     C_ALWAYS,   StIdle};
    endcase
    return w;
  endfunction

  logic [PC_WIDTH-1:0] pc;
  logic [PC_WIDTH-1:0] pc_next;
  uword_t              word;
  logic                taken;

  assign word = program_word(pc);

  always_comb begin
    case (word.cond)
      C_NEVER:    taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_NO_ITEM:  taken = !flags.item_valid;
      C_N_LT_2:   taken = flags.n_lt_2;
      C_SQ_GT_N:  taken = flags.sq_gt_n;
      C_DIV_BUSY: taken = flags.div_busy;
      C_REM_ZERO: taken = flags.rem_zero;
      C_OUT_BUSY: taken = flags.out_busy;
      default:    taken = 1'b1;
    endcase
  end

  assign pc_next   = taken ? word.target : pc + PC_WIDTH'(1);
  assign ctrl.op   = word.op;
  assign ctrl.take = (pc == StIdle);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= StIdle;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

@@ dv/prime_removal_filter_checker.sv @@
`timescale 1ns / 100ps

module prime_removal_filter_checker
  import prf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  logic      item_ready,
  input  in_item_t  item,
  input  logic      result_valid,
  input  logic      result_ready,
  input  out_item_t result,
  output int        outstanding,
  output int        fail_count
);

  out_item_t expected_verdicts[$];
  out_item_t oldest;
  int        errors = 0;

  function automatic bit prime_by_trial(logic [VALUE_WIDTH-1:0] n);
    longint unsigned d;
    if (n < 2) return 1'b0;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic out_item_t predict_verdict(in_item_t it);
    out_item_t v;
    v.value_out    = it.value;
    v.keep         = !prime_by_trial(it.value);
    v.end_mark_out = it.end_mark;
    return v;
  endfunction

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual value %0d keep %0b end %0b",
                   $time, result.value_out, result.keep, result.end_mark_out);
          errors++;
        end else begin
          oldest = expected_verdicts.pop_front();
          report_field("value_out", 32'(oldest.value_out), 32'(result.value_out));
          report_field("keep", 32'(oldest.keep), 32'(result.keep));
          report_field("end_mark_out", 32'(oldest.end_mark_out),
                       32'(result.end_mark_out));
        end
      end
      if (item_valid && item_ready) begin
        expected_verdicts.push_back(predict_verdict(item));
      end
    end
    outstanding <= expected_verdicts.size();
    fail_count  <= errors;
  end

endmodule

@@ dv/prime_removal_filter_tb.sv @@
`timescale 1ns / 100ps

module prime_removal_filter_tb;
  import prf_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_CYCLES = 6000;

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_ready;
  in_item_t  item;
  logic      result_valid;
  logic      result_ready;
  out_item_t result;
  int        outstanding;
  int        fail_count;
  int        idle_cycles;
  int        sent;
  bit        stall_free;

  prime_removal_filter uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  prime_removal_filter_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .outstanding  (outstanding),
    .fail_count   (fail_count)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (stall_free) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return VALUE_WIDTH'($urandom_range(0, 255));
    if (r < 75) return VALUE_WIDTH'($urandom_range(0, 4095));
    return VALUE_WIDTH'($urandom_range(0, 65535));
  endfunction

  task automatic send_item(input logic [VALUE_WIDTH-1:0] v, input logic e);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid    <= 1'b1;
    item.value    <= v;
    item.end_mark <= e;
    do @(posedge clk); while (!(item_valid && item_ready));
    sent++;
  endtask

  task automatic send_list(input bit broken);
    int len;
    len = $urandom_range(1, 8);
    for (int k = 0; k < len; k++) begin
      send_item(pick_value(), broken ? 1'($urandom_range(0, 1)) : 1'(k == len - 1));
    end
  endtask

  task automatic run_lists(input int count);
    int stop_at;
    stop_at = sent + count;
    while (sent < stop_at) send_list($urandom_range(0, 9) == 0);
  endtask

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int gap;
    int run;
    result_ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      result_ready <= 1'b1;
      run = $urandom_range(1, 20);
      repeat (run) @(posedge clk);
      gap = idle_len();
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    rst         <= 1'b1;
    item_valid  <= 1'b0;
    item        <= '0;
    sent        = 0;
    stall_free  = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Zero and one are kept, two is the smallest prime.
    send_item(16'd0, 1'b0);
    send_item(16'd1, 1'b0);
    send_item(16'd2, 1'b1);
    send_item(16'd3, 1'b0);
    send_item(16'd4, 1'b1);
    send_item(16'd9, 1'b0);
    send_item(16'd25, 1'b0);
    send_item(16'd49, 1'b1);
    send_item(16'd253, 1'b0);
    send_item(16'd257, 1'b0);
    send_item(16'd64507, 1'b1);
    send_item(16'd65025, 1'b0);
    send_item(16'd65521, 1'b1);
    send_item(16'd65535, 1'b0);
    send_item(16'd65534, 1'b1);
    send_item(16'd32768, 1'b0);
    send_item(16'h5555, 1'b1);
    send_item(16'hAAAA, 1'b0);
    send_item(16'd65519, 1'b1);
    send_item(16'd7, 1'b1);

    run_lists(450);
    stall_free = 1'b1;
    run_lists(250);
    stall_free = 1'b0;
    run_lists(550);

    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
